// ===== rtl/gbfp_pkg.sv =====
// Shared types and constants of the binary frame parser.
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

  // Frame parsing phases, one-hot
  typedef enum logic [7:0] {
    PH_WAIT    = 8'b0000_0001,
    PH_CLASS   = 8'b0000_0010,
    PH_ID      = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CHECK_A = 8'b0100_0000,
    PH_CHECK_B = 8'b1000_0000
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LONG = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH  = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] frames_good;
    logic [31:0] error_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/gnss_binary_frame_parser.sv =====
// Top level of the sync-framed binary message parser with Fletcher check.
//
// Usage: received bytes enter one per transfer on the input channel
// (in_valid_i / in_ready_o, rx_byte_i). Each byte gives at most one result
// on the output channel (out_valid_o / out_ready_i): a payload byte with its
// index and last mark, a frame accepted, a checksum mismatch, or a length
// over the limit, always with the running good and error totals.
// A byte accepted into the input register is parsed there, and its result
// enters the output register. Throughput: one byte per cycle while the
// output is not stalled, set by the single parse step between the input
// register and the output register. A stalled receiver holds the result
// in the output register; one more byte waits in the input register, after
// which in_ready_o drops. Bytes that give no result pass the parse step even
// while the output is held. Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i)
// writes sync_first, sync_second and max_length; the user writes it only
// while the block is idle, which the block does not enforce. Reset clears
// both registers' valid flags, returns the parser to waiting for sync,
// zeroes the totals and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_parser
  import gbfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          rx_byte_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               frame_class_o,
  output logic [7:0]               msg_id_o,
  output logic [15:0]              payload_length_o,
  output logic [15:0]              byte_index_o,
  output logic [7:0]               data_byte_o,
  output logic                     last_o,
  output logic [31:0]              frames_good_o,
  output logic [31:0]              error_count_o
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       res_valid;
  result_t    res;
  logic       advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.max_length  <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i[7:0];
        CFG_MAX_LENGTH:  cfg_q.max_length  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Parse a held byte unless its result would overwrite a waiting one
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  gbfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign frame_class_o    = out_q.frame_class;
  assign msg_id_o         = out_q.msg_id;
  assign payload_length_o = out_q.payload_length;
  assign byte_index_o     = out_q.byte_index;
  assign data_byte_o      = out_q.data_byte;
  assign last_o           = out_q.last;
  assign frames_good_o    = out_q.frames_good;
  assign error_count_o    = out_q.error_count;

endmodule

`default_nettype wire

// ===== rtl/gbfp_parser.sv =====
// Frame state, Fletcher sums and counters; one received byte per step.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_parser
  import gbfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t    cfg_i,
  output logic         res_valid_o,
  output result_t      res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  prev_q;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  check_a_q, check_a_d;
  logic [31:0] good_q, good_d;
  logic [31:0] err_q, err_d;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] length_full;
  logic        is_last;

  // Running Fletcher sums with this byte included
  assign sum_a_add   = sum_a_q + byte_i;
  assign sum_b_add   = sum_b_q + sum_a_add;
  assign length_full = {byte_i, length_q[7:0]};
  assign is_last     = ({1'b0, count_q} + 17'd1) >= {1'b0, length_q};

  // Next-state and result logic
  always_comb begin
    phase_d     = phase_q;
    class_d     = class_q;
    id_d        = id_q;
    length_d    = length_q;
    count_d     = count_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    check_a_d   = check_a_q;
    good_d      = good_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    res_o.kind       = KIND_DATA;
    res_o.byte_index = '0;
    res_o.data_byte  = '0;
    res_o.last       = 1'b0;

    unique case (phase_q)
      PH_WAIT: begin
        if (byte_i == cfg_i.sync_second && prev_q == cfg_i.sync_first) begin
          class_d   = '0;
          id_d      = '0;
          length_d  = '0;
          count_d   = '0;
          sum_a_d   = '0;
          sum_b_d   = '0;
          check_a_d = '0;
          phase_d   = PH_CLASS;
        end
      end
      PH_CLASS: begin
        class_d = byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_d = {8'd0, byte_i};
        sum_a_d  = sum_a_add;
        sum_b_d  = sum_b_add;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = length_full;
        sum_a_d  = sum_a_add;
        sum_b_d  = sum_b_add;
        if (length_full > cfg_i.max_length) begin
          err_d       = err_q + 32'd1;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_LONG;
          phase_d     = PH_WAIT;
        end else if (length_full == 16'd0) begin
          phase_d = PH_CHECK_A;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_d          = sum_a_add;
        sum_b_d          = sum_b_add;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_DATA;
        res_o.byte_index = count_q;
        res_o.data_byte  = byte_i;
        res_o.last       = is_last;
        count_d          = count_q + 16'd1;
        if (is_last) begin
          phase_d = PH_CHECK_A;
        end
      end
      PH_CHECK_A: begin
        check_a_d = byte_i;
        phase_d   = PH_CHECK_B;
      end
      PH_CHECK_B: begin
        res_valid_o = 1'b1;
        if (check_a_q == sum_a_q && byte_i == sum_b_q) begin
          good_d     = good_q + 32'd1;
          res_o.kind = KIND_GOOD;
        end else begin
          err_d      = err_q + 32'd1;
          res_o.kind = KIND_BAD;
        end
        phase_d = PH_WAIT;
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase

    // Frame fields and totals as they stand after this byte
    res_o.frame_class    = class_d;
    res_o.msg_id         = id_d;
    res_o.payload_length = length_d;
    res_o.frames_good    = good_d;
    res_o.error_count    = err_d;
  end

  // State registers, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      prev_q    <= '0;
      class_q   <= '0;
      id_q      <= '0;
      length_q  <= '0;
      count_q   <= '0;
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      check_a_q <= '0;
      good_q    <= '0;
      err_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      prev_q    <= byte_i;
      class_q   <= class_d;
      id_q      <= id_d;
      length_q  <= length_d;
      count_q   <= count_d;
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      check_a_q <= check_a_d;
      good_q    <= good_d;
      err_q     <= err_d;
    end
  end

  // Checks
  a_check_b_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHECK_B |=> phase_q == PH_WAIT)
    else $error("frame did not end after second check byte");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> count_q < length_q)
    else $error("payload count reached declared length inside payload");

  a_good_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == KIND_GOOD |=> good_q == $past(good_q) + 32'd1)
    else $error("good frame total not advanced");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(err_q) && $stable(good_q))
    else $error("parser state moved without a byte");

  a_len_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == KIND_LONG |=> phase_q == PH_WAIT)
    else $error("over-length frame not dropped");

endmodule

`default_nettype wire
